// ===== rtl/vle_pkg.sv =====
`default_nettype none

package vle_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_SP = 8'h20;
  localparam logic [7:0] BYTE_DEL = 8'h7F;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_UP = 8'h41;

  localparam logic [1:0] OP_PRINT = 2'd0;
  localparam logic [1:0] OP_BS = 2'd1;
  localparam logic [1:0] OP_RECALL = 2'd2;
  localparam logic [1:0] OP_CR = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] prompt_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0: c = 8'h63;
      2'd1: c = 8'h6D;
      2'd2: c = 8'h64;
      default: c = 8'h3E;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vt100_line_editor.sv =====
`default_nettype none

// Terminal line editor: received bytes are pushed in as words, and echo bytes
// (kind 0) and finished command lines (kind 1) come out as words, with last set
// on the final word caused by each received byte. A front stage tracks escape
// sequences and queues edit commands in a two-word queue; a back sequencer
// carries them out against the line and history RAMs and drives one output
// word per cycle into the output register while that register is free or being
// popped. A printable byte or backspace passes through the queue slot and then
// the output register before its echo appears; backspace echoes BS, space, BS,
// a history recall of L bytes echoes those L bytes, and a carriage return with an
// L-byte line emits CR, LF, the L line bytes and the four-byte prompt. The input
// stalls only when the command queue is full; bytes that yield no output are
// also accepted whenever the queue is not full. Lines hold up to LINE_CAPACITY
// bytes; further printables are echoed but not stored.
module vt100_line_editor
  import vle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] rx_byte,
  input  wire logic       push,
  output logic            full,
  output logic [7:0]      out_byte,
  output logic            out_kind,
  output logic            last,
  output logic            empty,
  input  wire logic       pop
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_empty;
  logic q_pop;
  cmd_t q_cmd;

  assign accept = push && !full;

  vle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .accept   (accept),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  vle_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_valid),
    .wr_cmd (cmd),
    .q_full (full),
    .q_empty(q_empty),
    .rd_en  (q_pop),
    .rd_cmd (q_cmd)
  );

  vle_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_byte(out_byte),
    .out_kind(out_kind),
    .last    (last),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

`default_nettype wire

// ===== rtl/vle_ram.sv =====
`default_nettype none

module vle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/vle_front.sv =====
`default_nettype none

module vle_front
  import vle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] rx_byte,
  input  wire logic       accept,
  output logic            cmd_valid,
  output cmd_t            cmd
);

  localparam logic [1:0] ESC_NORMAL = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_BRACKET = 2'd2;

  logic [1:0] esc_state;
  logic [1:0] esc_state_next;

  always_comb begin
    esc_state_next = esc_state;
    cmd_valid = 1'b0;
    cmd.op = OP_PRINT;
    cmd.data = rx_byte;
    if (accept) begin
      case (esc_state)
        ESC_SEEN: begin
          esc_state_next = (rx_byte == BYTE_LBRACKET) ? ESC_BRACKET : ESC_NORMAL;
        end
        ESC_BRACKET: begin
          esc_state_next = ESC_NORMAL;
          if (rx_byte == BYTE_UP) begin
            cmd_valid = 1'b1;
            cmd.op = OP_RECALL;
          end
        end
        default: begin
          esc_state_next = ESC_NORMAL;
          if (rx_byte == BYTE_ESC) begin
            esc_state_next = ESC_SEEN;
          end else if (rx_byte == BYTE_CR) begin
            cmd_valid = 1'b1;
            cmd.op = OP_CR;
          end else if (rx_byte == BYTE_BS) begin
            cmd_valid = 1'b1;
            cmd.op = OP_BS;
          end else if (rx_byte inside {[BYTE_SP : BYTE_DEL - 8'd1]}) begin
            cmd_valid = 1'b1;
            cmd.op = OP_PRINT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_state <= ESC_NORMAL;
    end else begin
      esc_state <= esc_state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vle_cmd_queue.sv =====
`default_nettype none

module vle_cmd_queue
  import vle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  cmd_t      wr_cmd,
  output logic      q_full,
  output logic      q_empty,
  input  wire logic rd_en,
  output cmd_t      rd_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vle_back.sv =====
`default_nettype none

module vle_back
  import vle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  cmd_t            q_cmd,
  output logic            q_pop,
  output logic [7:0]      out_byte,
  output logic            out_kind,
  output logic            last,
  output logic            empty,
  input  wire logic       pop
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BS_SP = 3'd1;
  localparam logic [2:0] S_BS_END = 3'd2;
  localparam logic [2:0] S_RECALL = 3'd3;
  localparam logic [2:0] S_LF = 3'd4;
  localparam logic [2:0] S_LINE = 3'd5;
  localparam logic [2:0] S_PROMPT = 3'd6;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] idx_next;
  logic [1:0]        pidx;
  logic [1:0]        pidx_next;
  logic [LEN_W-1:0]  line_len;
  logic [LEN_W-1:0]  line_len_next;
  logic [LEN_W-1:0]  hist_len;
  logic [LEN_W-1:0]  hist_len_next;
  logic              out_valid;

  logic              out_free;
  logic              emit;
  logic [7:0]        e_byte;
  logic              e_kind;
  logic              e_last;

  logic              line_we;
  logic [ADDR_W-1:0] line_waddr;
  logic [7:0]        line_wdata;
  logic [7:0]        line_rd;
  logic              hist_we;
  logic [7:0]        hist_rd;
  logic [LEN_W-1:0]  idx_ext;

  // both stores are read at idx_next, so rd data always matches idx
  vle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_line_ram (
    .clk  (clk),
    .we   (line_we),
    .waddr(line_waddr),
    .wdata(line_wdata),
    .raddr(idx_next),
    .rdata(line_rd)
  );

  vle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_hist_ram (
    .clk  (clk),
    .we   (hist_we),
    .waddr(idx),
    .wdata(line_rd),
    .raddr(idx_next),
    .rdata(hist_rd)
  );

  assign out_free = !out_valid || pop;
  assign empty = !out_valid;
  assign idx_ext = LEN_W'(idx);

  always_comb begin
    state_next = state;
    idx_next = idx;
    pidx_next = pidx;
    line_len_next = line_len;
    hist_len_next = hist_len;
    q_pop = 1'b0;
    emit = 1'b0;
    e_byte = BYTE_SP;
    e_kind = 1'b0;
    e_last = 1'b0;
    line_we = 1'b0;
    line_waddr = idx;
    line_wdata = hist_rd;
    hist_we = 1'b0;
    if (out_free) begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            q_pop = 1'b1;
            case (q_cmd.op)
              OP_PRINT: begin
                emit = 1'b1;
                e_byte = q_cmd.data;
                e_last = 1'b1;
                if (line_len < LEN_W'(LINE_CAPACITY)) begin
                  line_we = 1'b1;
                  line_waddr = line_len[ADDR_W-1:0];
                  line_wdata = q_cmd.data;
                  line_len_next = line_len + LEN_W'(1);
                end
              end
              OP_BS: begin
                if (line_len != '0) begin
                  line_len_next = line_len - LEN_W'(1);
                  emit = 1'b1;
                  e_byte = BYTE_BS;
                  state_next = S_BS_SP;
                end
              end
              OP_RECALL: begin
                line_len_next = hist_len;
                idx_next = '0;
                if (hist_len != '0) begin
                  state_next = S_RECALL;
                end
              end
              default: begin
                if (line_len != '0) begin
                  hist_len_next = line_len;
                end
                pidx_next = 2'd0;
                emit = 1'b1;
                e_byte = BYTE_CR;
                state_next = S_LF;
              end
            endcase
          end
        end
        S_BS_SP: begin
          emit = 1'b1;
          e_byte = BYTE_SP;
          state_next = S_BS_END;
        end
        S_BS_END: begin
          emit = 1'b1;
          e_byte = BYTE_BS;
          e_last = 1'b1;
          state_next = S_IDLE;
        end
        S_RECALL: begin
          emit = 1'b1;
          e_byte = hist_rd;
          e_last = (idx_ext == hist_len - LEN_W'(1));
          line_we = 1'b1;
          if (e_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + ADDR_W'(1);
          end
        end
        S_LF: begin
          emit = 1'b1;
          e_byte = BYTE_LF;
          idx_next = '0;
          state_next = (line_len != '0) ? S_LINE : S_PROMPT;
        end
        S_LINE: begin
          emit = 1'b1;
          e_byte = line_rd;
          e_kind = 1'b1;
          hist_we = 1'b1;
          if (idx_ext == line_len - LEN_W'(1)) begin
            state_next = S_PROMPT;
          end else begin
            idx_next = idx + ADDR_W'(1);
          end
        end
        S_PROMPT: begin
          emit = 1'b1;
          e_byte = prompt_char(pidx);
          e_last = (pidx == 2'd3);
          pidx_next = pidx + 2'd1;
          if (e_last) begin
            line_len_next = '0;
            state_next = S_IDLE;
          end
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      line_len <= '0;
      hist_len <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      line_len <= line_len_next;
      hist_len <= hist_len_next;
      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    pidx <= pidx_next;
    if (out_free && emit) begin
      out_byte <= e_byte;
      out_kind <= e_kind;
      last <= e_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vle_checker.sv =====
`default_nettype none

module vle_checker
  import vle_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic [7:0] out_byte,
  input wire logic       out_kind,
  input wire logic       last,
  input wire logic       empty,
  input wire logic       pop
);

  // a waiting word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_kind) && $stable(last)))
    else $error("output word changed while stalled");

  // a command line is always followed by the prompt
  a_line_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind) |-> !last)
    else $error("line word marked last");

  a_line_printable: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind) |-> (out_byte >= BYTE_SP && out_byte < BYTE_DEL))
    else $error("line word not printable");

  // line words run without gaps into the prompt
  a_line_flow: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_kind) |=> (!empty && (out_kind || out_byte == prompt_char(2'd0))))
    else $error("line word not followed by line or prompt");

  a_cr_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_kind && out_byte == BYTE_CR) |-> !last)
    else $error("carriage return echo marked last");

endmodule

bind vt100_line_editor vle_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .out_byte(out_byte),
  .out_kind(out_kind),
  .last    (last),
  .empty   (empty),
  .pop     (pop)
);

`default_nettype wire
